/* src/btl_pkg.sv */
// ----------------------------------------------------------------------------
// btl_pkg: shared types and constants for the binary trie lookup core
// record layout codes, result codes, register indexes, fetch unit control
// ----------------------------------------------------------------------------
package btl_pkg;

  localparam int NODE_W   = 19;   // node index width
  localparam int OFF_W    = 23;   // byte offset of any record byte of a legal node
  localparam int VALUE_W  = 32;   // record value width
  localparam int SEP_LEN  = 16;   // gap between the tree and the data section
  localparam int CFG_IDX_W = 2;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_WRITTEN   = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FOUND     = 3'd2,
    ST_INVALID   = 3'd3,
    ST_NO_V4     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MODE_24 = 2'd0,
    MODE_28 = 2'd1,
    MODE_32 = 2'd2,
    MODE_32_ALT = 2'd3
  } rec_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT  = 2'd0,
    CFG_RECORD_MODE = 2'd1,
    CFG_TREE_IS_V6  = 2'd2,
    CFG_DATA_WINDOW = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] NIBBLE_HI = 8'hF0;
  localparam logic [7:0] NIBBLE_LO = 8'h0F;

  typedef struct packed {
    logic              start;
    logic [NODE_W-1:0] node;
    logic              side;
    rec_mode_t         mode;
  } fetch_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] record;
  } fetch_rsp_t;

  // byte position inside a node of the k-th byte fetched for one record
  // the 28-bit form fetches the shared nibble byte first
  function automatic logic [2:0] rel_off(rec_mode_t mode, logic side, logic [1:0] k);
    logic [2:0] r;
    r = 3'd0;
    case (mode)
      MODE_24: r = side ? (3'd3 + 3'(k)) : 3'(k);
      MODE_28: begin
        if (k == 2'd0) begin
          r = 3'd3;
        end else begin
          r = side ? (3'd3 + 3'(k)) : (3'(k) - 3'd1);
        end
      end
      default: r = side ? (3'd4 + 3'(k)) : 3'(k);
    endcase
    return r;
  endfunction

endpackage

/* src/btl_in_if.sv */
// ----------------------------------------------------------------------------
// btl_in_if: request channel of the trie lookup core
// valid/ready handshake carrying one write or lookup request
// ----------------------------------------------------------------------------
interface btl_in_if;
  logic             valid;
  logic             ready;
  btl_pkg::op_t     operation;
  logic [19:0]      byte_address;
  logic [7:0]       byte_value;
  logic [31:0]      ip_address;

  modport source (output valid, operation, byte_address, byte_value, ip_address,
                  input ready);
  modport sink (input valid, operation, byte_address, byte_value, ip_address,
                output ready);
endinterface

/* src/btl_out_if.sv */
// ----------------------------------------------------------------------------
// btl_out_if: result channel of the trie lookup core
// valid/ready handshake carrying one status and record value
// ----------------------------------------------------------------------------
interface btl_out_if;
  logic              valid;
  logic              ready;
  btl_pkg::status_t  status;
  logic [31:0]       record_value;

  modport source (output valid, status, record_value, input ready);
  modport sink (input valid, status, record_value, output ready);
endinterface

/* src/btl_ram.sv */
// ----------------------------------------------------------------------------
// btl_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module btl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1048576
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/btl_rec_fetch.sv */
// ----------------------------------------------------------------------------
// btl_rec_fetch: record fetch unit
// computes a node's byte offset and reads one record a byte per cycle
// ----------------------------------------------------------------------------
module btl_rec_fetch #(
  parameter int TREE_BYTES = 1048576
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  btl_pkg::fetch_req_t           req,
  output btl_pkg::fetch_rsp_t           rsp,
  output logic [$clog2(TREE_BYTES)-1:0] rd_addr,
  input  logic [7:0]                    rd_data
);

  localparam int AW = $clog2(TREE_BYTES);

  logic                      busy_r;
  logic                      rd_vld_r;
  logic [btl_pkg::OFF_W-1:0] base_r;
  logic [btl_pkg::OFF_W-1:0] base_nxt;
  logic                      side_r;
  btl_pkg::rec_mode_t        mode_r;
  logic [2:0]                k_r;
  logic [1:0]                rd_k_r;
  logic                      rd_oob_r;
  logic [23:0]               acc_r;

  logic [2:0]                nb;
  logic                      issue;
  logic [btl_pkg::OFF_W-1:0] off;
  logic [31:0]               off_ext;
  logic                      oob;
  logic [7:0]                byte_q;
  logic [7:0]                part;
  logic                      last;
  logic [btl_pkg::OFF_W-1:0] node_ext;

  assign node_ext = btl_pkg::OFF_W'(req.node);

  // node times stride: 6, 7 or 8 bytes
  always_comb begin
    case (req.mode)
      btl_pkg::MODE_24: base_nxt = (node_ext << 2) + (node_ext << 1);
      btl_pkg::MODE_28: base_nxt = (node_ext << 3) - node_ext;
      default:          base_nxt = node_ext << 3;
    endcase
  end

  assign nb      = (mode_r == btl_pkg::MODE_24) ? 3'd3 : 3'd4;
  assign issue   = busy_r && (k_r < nb);
  assign off     = base_r + btl_pkg::OFF_W'(btl_pkg::rel_off(mode_r, side_r, k_r[1:0]));
  assign off_ext = 32'(off);
  assign oob     = off_ext >= 32'(TREE_BYTES);
  assign rd_addr = off_ext[AW-1:0];

  // bytes past the end of the memory read as zero
  assign byte_q = rd_oob_r ? 8'h00 : rd_data;

  always_comb begin
    part = byte_q;
    if (mode_r == btl_pkg::MODE_28 && rd_k_r == 2'd0) begin
      part = side_r ? (byte_q & btl_pkg::NIBBLE_LO) : ((byte_q & btl_pkg::NIBBLE_HI) >> 4);
    end
  end

  assign last       = rd_vld_r && (3'(rd_k_r) == (nb - 3'd1));
  assign rsp.done   = last;
  assign rsp.record = {acc_r, part};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else if (req.start) begin
      busy_r   <= 1'b1;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      base_r <= base_nxt;
      side_r <= req.side;
      mode_r <= req.mode;
      k_r    <= 3'd0;
      acc_r  <= 24'd0;
    end else begin
      if (issue) begin
        k_r <= k_r + 3'd1;
      end
      if (rd_vld_r) begin
        acc_r <= {acc_r[15:0], part};
      end
    end
    rd_k_r   <= k_r[1:0];
    rd_oob_r <= oob;
  end

endmodule

/* src/ip_binary_trie_lookup_core.sv */
// ----------------------------------------------------------------------------
// ip_binary_trie_lookup_core: IPv4 longest-prefix walk over a byte-wide tree
// write beats load tree bytes, lookup beats walk the tree one record a step
// ----------------------------------------------------------------------------
// a write goes straight to its result beat; a lookup reads one record per
//   step, three bytes for 24-bit records and four for the other layouts
// one request at a time; an IPv4 tree walk is up to 32 records, a v6 tree
//   adds up to PREFIX_ZERO_BITS records first
// the step cost is set by the single byte-wide read port of the tree memory
// reset: synchronous active-low; control and config regs reset, tree memory kept
module ip_binary_trie_lookup_core #(
  parameter int TREE_BYTES       = 1048576,
  parameter int PREFIX_ZERO_BITS = 96
) (
  input  logic                             clk,
  input  logic                             rst_n,
  btl_in_if.sink                           in_ch,
  btl_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [btl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_wdata
);

  localparam int AW    = $clog2(TREE_BYTES);
  // step counter covers both the prefix walk and the 32 address bits
  localparam int CNT_W = (PREFIX_ZERO_BITS > 32) ? $clog2(PREFIX_ZERO_BITS + 1) : 6;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_FETCH = 6'b000100,
    S_BOUND = 6'b001000,
    S_CLASS = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // configuration registers
  logic [btl_pkg::NODE_W-1:0] node_count_r;
  btl_pkg::rec_mode_t         rec_mode_r;
  logic                       tree_is_v6_r;
  logic [31:0]                win_r;

  // sequencer
  state_t                      state_r, state_nxt;
  logic [31:0]                 v_r, v_nxt;          // current walk value
  logic [31:0]                 ip_r, ip_nxt;        // address bits, msb next
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;      // steps taken in this phase
  logic                        pfx_r, pfx_nxt;      // in the v6 zero-prefix walk
  btl_pkg::status_t            res_r, res_nxt;
  logic [btl_pkg::NODE_W:0]    lo_r, lo_nxt;        // start of data window
  logic [32:0]                 hi_r, hi_nxt;        // end of data window

  // result register, lets a new request in while a result waits
  logic                        out_valid_r, out_valid_nxt;
  btl_pkg::status_t            out_status_r;
  logic [31:0]                 out_value_r;
  logic                        out_load;

  logic                        in_fire;
  logic                        v_ge;
  logic [31:0]                 count_ext;
  logic                        wr_en;
  logic [31:0]                 wr_ext;

  btl_pkg::fetch_req_t         fetch_req;
  btl_pkg::fetch_rsp_t         fetch_rsp;
  logic [AW-1:0]               rd_addr;
  logic [7:0]                  rd_data;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // tree writes beyond the memory are dropped but still answered
  assign wr_ext = 32'(in_ch.byte_address);
  assign wr_en  = in_fire && (in_ch.operation == btl_pkg::OP_WRITE) &&
                  (wr_ext < 32'(TREE_BYTES));

  btl_ram #(
    .WIDTH (8),
    .DEPTH (TREE_BYTES)
  ) u_tree_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_ext[AW-1:0]),
    .wdata (in_ch.byte_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  btl_rec_fetch #(
    .TREE_BYTES (TREE_BYTES)
  ) u_fetch (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (fetch_req),
    .rsp     (fetch_rsp),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= btl_pkg::NODE_W'(1);
      rec_mode_r   <= btl_pkg::MODE_24;
      tree_is_v6_r <= 1'b0;
      win_r        <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btl_pkg::CFG_NODE_COUNT:  node_count_r <= cfg_wdata[btl_pkg::NODE_W-1:0];
        btl_pkg::CFG_RECORD_MODE: rec_mode_r   <= btl_pkg::rec_mode_t'(cfg_wdata[1:0]);
        btl_pkg::CFG_TREE_IS_V6:  tree_is_v6_r <= cfg_wdata[0];
        btl_pkg::CFG_DATA_WINDOW: win_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign count_ext = 32'(node_count_r);
  // the walk leaves the tree once the value reaches the node count
  assign v_ge      = v_r >= count_ext;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt       = state_r;
    v_nxt           = v_r;
    ip_nxt          = ip_r;
    cnt_nxt         = cnt_r;
    pfx_nxt         = pfx_r;
    res_nxt         = res_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    fetch_req.start = 1'b0;
    fetch_req.node  = v_r[btl_pkg::NODE_W-1:0];
    fetch_req.side  = 1'b0;
    fetch_req.mode  = rec_mode_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          v_nxt   = 32'd0;
          ip_nxt  = in_ch.ip_address;
          cnt_nxt = '0;
          pfx_nxt = tree_is_v6_r;
          if (in_ch.operation == btl_pkg::OP_WRITE) begin
            res_nxt   = btl_pkg::ST_WRITTEN;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        if (pfx_r) begin
          // zero-prefix walk: left records only
          if (v_ge) begin
            res_nxt   = btl_pkg::ST_NO_V4;
            state_nxt = S_DONE;
          end else if (cnt_r == CNT_W'(PREFIX_ZERO_BITS)) begin
            pfx_nxt = 1'b0;
            cnt_nxt = '0;
          end else begin
            fetch_req.start = 1'b1;
            cnt_nxt         = cnt_r + CNT_W'(1);
            state_nxt       = S_FETCH;
          end
        end else begin
          // address walk: one record per address bit
          if (v_ge || cnt_r == CNT_W'(32)) begin
            state_nxt = S_BOUND;
          end else begin
            fetch_req.start = 1'b1;
            fetch_req.side  = ip_r[31];
            ip_nxt          = ip_r << 1;
            cnt_nxt         = cnt_r + CNT_W'(1);
            state_nxt       = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        if (fetch_rsp.done) begin
          v_nxt     = fetch_rsp.record;
          state_nxt = S_CHECK;
        end
      end

      S_BOUND: begin
        lo_nxt    = (btl_pkg::NODE_W + 1)'(node_count_r) +
                    (btl_pkg::NODE_W + 1)'(btl_pkg::SEP_LEN);
        hi_nxt    = 33'(node_count_r) + 33'(btl_pkg::SEP_LEN) + 33'(win_r);
        state_nxt = S_CLASS;
      end

      S_CLASS: begin
        // values below the node count also fall under the window start
        if (v_r == count_ext) begin
          res_nxt = btl_pkg::ST_NOT_FOUND;
        end else if (v_r < 32'(lo_r) || 33'(v_r) >= hi_r) begin
          res_nxt = btl_pkg::ST_INVALID;
        end else begin
          res_nxt = btl_pkg::ST_FOUND;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pfx_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pfx_r   <= pfx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    ip_r  <= ip_nxt;
    res_r <= res_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
  end

  // output beat register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_r;
      out_value_r  <= v_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.record_value = out_value_r;

endmodule

/* tb/ip_binary_trie_lookup_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_binary_trie_lookup_core_tb: self-checking bench for the trie lookup core
// builds small search trees through write beats under every record layout,
// then walks them with lookup beats; a shadow tree and walker in the bench
// predict each result beat, which is checked field by field in arrival order
// ----------------------------------------------------------------------------
module ip_binary_trie_lookup_core_tb;
  import btl_pkg::*;

  localparam int TREE_SIZE   = 1048576;
  localparam int PREFIX_BITS = 96;
  localparam int ITEM_GOAL   = 1950;
  localparam int IDLE_PCT    = 34;

  typedef struct {
    status_t     status;
    logic [31:0] value;
  } lookup_answer_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  btl_in_if  in_ch ();
  btl_out_if out_ch ();

  ip_binary_trie_lookup_core #(
    .TREE_BYTES      (TREE_SIZE),
    .PREFIX_ZERO_BITS(PREFIX_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the tree memory; bytes never written must never be walked
  logic [7:0] tree_mem [TREE_SIZE];
  bit         tree_written [TREE_SIZE];
  bit         blank_read;

  // shadow of the configuration registers, reset values
  logic [NODE_W-1:0] cfg_nodes  = 19'd1;
  rec_mode_t         cfg_mode   = MODE_24;
  bit                cfg_v6     = 1'b0;
  logic [31:0]       cfg_window = 32'd0;

  // answers predicted at request acceptance, oldest first
  lookup_answer_t pending_answers [$];
  lookup_answer_t oldest_answer;

  int  mismatch_count;
  int  answers_checked;
  int  items_sent;
  int  lookups_sent;
  int  writes_sent;
  int  settings_loaded;
  int  outcome_tally [5];
  bit  no_idle;
  int  hold_off_cycles;
  int  hold_count;

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: far beyond the slowest legal run (every lookup a full v6 walk)
  initial begin
    #100_000_000;
    $display("timeout: %0d answers still pending", pending_answers.size());
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // one tree byte; anything past the end of the memory reads as zero
  function automatic logic [7:0] peek(longint unsigned off);
    if (off >= TREE_SIZE) return 8'h00;
    if (!tree_written[off]) blank_read = 1'b1;
    return tree_mem[off];
  endfunction

  function automatic int node_size();
    case (cfg_mode)
      MODE_24: return 6;
      MODE_28: return 7;
      default: return 8;
    endcase
  endfunction

  // left or right record of one node under the current layout
  function automatic longint unsigned read_record(longint unsigned node, bit side);
    longint unsigned base;
    logic [7:0] b0, b1, b2, b3;
    case (cfg_mode)
      MODE_24: begin
        base = node * 6 + (side ? 3 : 0);
        b0 = peek(base);
        b1 = peek(base + 1);
        b2 = peek(base + 2);
        return {b0, b1, b2};
      end
      MODE_28: begin
        // shared middle byte: high nibble to the left record, low to the right
        base = node * 7;
        b3 = peek(base + 3);
        base = base + (side ? 4 : 0);
        b0 = peek(base);
        b1 = peek(base + 1);
        b2 = peek(base + 2);
        return {(side ? b3[3:0] : b3[7:4]), b0, b1, b2};
      end
      default: begin
        // mode 3 behaves as 32-bit records
        base = node * 8 + (side ? 4 : 0);
        b0 = peek(base);
        b1 = peek(base + 1);
        b2 = peek(base + 2);
        b3 = peek(base + 3);
        return {b0, b1, b2, b3};
      end
    endcase
  endfunction

  // full lookup: optional v6 prefix walk, then one step per address bit
  function automatic void trie_walk(input logic [31:0] ip, output status_t st,
                                    output logic [31:0] value);
    longint unsigned v, count, lo, hi;
    int step;
    v = 0;
    count = cfg_nodes;
    if (cfg_v6) begin
      for (step = 0; step < PREFIX_BITS && v < count; step++) v = read_record(v, 1'b0);
      if (v >= count) begin
        st = ST_NO_V4;
        value = v[31:0];
        return;
      end
    end
    for (step = 0; step < 32 && v < count; step++) v = read_record(v, ip[31-step]);
    lo = count + SEP_LEN;
    hi = lo + cfg_window;
    if (v == count) st = ST_NOT_FOUND;
    else if (v < lo || v >= hi) st = ST_INVALID;
    else st = ST_FOUND;
    value = v[31:0];
  endfunction

  function automatic bit walk_is_safe(logic [31:0] ip);
    status_t st;
    logic [31:0] value;
    blank_read = 1'b0;
    trie_walk(ip, st, value);
    return !blank_read;
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // ready: random idling, a quiet stretch on request, and one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        hold_count = hold_off_cycles;
        hold_off_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (hold_count) @(posedge clk);
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // every accepted result beat is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: status %0d value %h",
                   out_ch.status, out_ch.record_value);
      end else begin
        oldest_answer = pending_answers.pop_front();
        answers_checked++;
        outcome_tally[oldest_answer.status]++;
        if (out_ch.status !== oldest_answer.status ||
            out_ch.record_value !== oldest_answer.value) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected status %s value %h, got status %0d value %h",
                     answers_checked, oldest_answer.status.name(), oldest_answer.value,
                     out_ch.status, out_ch.record_value);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request beat; valid stays high afterwards unless the next call idles
  task automatic send_item(op_t op, logic [19:0] addr, logic [7:0] data, logic [31:0] ip);
    lookup_answer_t ans;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.byte_address <= addr;
    in_ch.byte_value   <= data;
    in_ch.ip_address   <= ip;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    // accepted at this edge: update the shadow and predict
    if (op == OP_WRITE) begin
      tree_mem[addr] = data;
      tree_written[addr] = 1'b1;
      ans = '{ST_WRITTEN, 32'd0};
      writes_sent++;
    end else begin
      trie_walk(ip, ans.status, ans.value);
      lookups_sent++;
    end
    pending_answers.push_back(ans);
    items_sent++;
  endtask

  // let the core finish everything before touching its registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write; the enable stays high for back-to-back writes
  task automatic put_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_NODE_COUNT:  cfg_nodes  = data[NODE_W-1:0];
      CFG_RECORD_MODE: cfg_mode   = rec_mode_t'(data[1:0]);
      CFG_TREE_IS_V6:  cfg_v6     = data[0];
      CFG_DATA_WINDOW: cfg_window = data;
      default: ;
    endcase
  endtask

  task automatic load_config(rec_mode_t mode, bit v6, int nodes, logic [31:0] window);
    drain();
    put_reg(CFG_NODE_COUNT, 32'(nodes));
    put_reg(CFG_RECORD_MODE, 32'(mode));
    put_reg(CFG_TREE_IS_V6, 32'(v6));
    put_reg(CFG_DATA_WINDOW, window);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // one record for a tree of n_nodes built nodes; never points at a node
  // that is inside the memory but not built
  function automatic logic [31:0] make_record(int node, int n_nodes, int bpn,
                                              longint unsigned rec_max);
    longint unsigned count, lo, r;
    int pick;
    count = cfg_nodes;
    lo = count + SEP_LEN;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // mostly forward pointers so walks reach a leaf; a few loop back
      if (node + 1 < n_nodes && pick >= 3) r = $urandom_range(n_nodes - 1, node + 1);
      else r = $urandom_range(n_nodes - 1, 0);
    end else if (pick < 60) begin
      r = count;
    end else if (pick < 80 && cfg_window != 0) begin
      r = lo + ($urandom % cfg_window);
    end else if (pick < 90) begin
      // just past the node count, or just past the data window
      if ($urandom_range(1)) r = count + $urandom_range(15, 1);
      else r = lo + cfg_window + $urandom_range(7);
    end else if (pick < 95) begin
      r = rec_max;
    end else begin
      // anywhere below the count: nodes past the memory end read as zero
      r = (count == 0) ? 0 : $urandom_range(count - 1, 0);
    end
    if (r > rec_max) r = rec_max;
    if (r < count && r >= n_nodes && r * bpn < TREE_SIZE) r = count;
    return r[31:0];
  endfunction

  // write nodes 0..n_nodes-1 byte by byte in the current layout
  task automatic build_tree(int n_nodes);
    logic [31:0] left_rec, right_rec;
    logic [7:0] nb [8];
    longint unsigned rec_max;
    int bpn, node, k;
    bpn = node_size();
    case (cfg_mode)
      MODE_24: rec_max = 64'h00FF_FFFF;
      MODE_28: rec_max = 64'h0FFF_FFFF;
      default: rec_max = 64'hFFFF_FFFF;
    endcase
    for (node = 0; node < n_nodes; node++) begin
      // v6 trees: node 0 usually loops on itself so the prefix walk survives
      if (cfg_v6 && node == 0 && $urandom_range(99) < 60) left_rec = 32'd0;
      else left_rec = make_record(node, n_nodes, bpn, rec_max);
      right_rec = make_record(node, n_nodes, bpn, rec_max);
      case (cfg_mode)
        MODE_24: {nb[0], nb[1], nb[2], nb[3], nb[4], nb[5]} =
                   {left_rec[23:0], right_rec[23:0]};
        MODE_28: {nb[0], nb[1], nb[2], nb[3], nb[4], nb[5], nb[6]} =
                   {left_rec[23:0], left_rec[27:24], right_rec[27:24], right_rec[23:0]};
        default: {nb[0], nb[1], nb[2], nb[3], nb[4], nb[5], nb[6], nb[7]} =
                   {left_rec, right_rec};
      endcase
      for (k = 0; k < bpn; k++)
        send_item(OP_WRITE, 20'(node * bpn + k), nb[k], $urandom);
    end
  endtask

  // one register setting: fresh tree, then lookups mixed with stray writes
  task automatic run_phase(rec_mode_t mode, bit v6, int nodes, logic [31:0] window,
                           int lookups, int hold);
    int n_nodes, i, tries, pick;
    logic [31:0] ip;
    bit safe;
    load_config(mode, v6, nodes, window);
    n_nodes = (nodes < 16) ? nodes : $urandom_range(16, 4);
    build_tree(n_nodes);
    hold_off_cycles = hold;
    for (i = 0; i < lookups; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // stray write anywhere in the byte space
        send_item(OP_WRITE, 20'($urandom), 8'($urandom), $urandom);
      end else if (pick < 11 && n_nodes != 0) begin
        // corrupt one tree byte; unsafe walks are filtered below
        send_item(OP_WRITE, 20'($urandom_range(n_nodes * node_size() - 1)),
                  8'($urandom), $urandom);
      end else begin
        tries = 0;
        do begin
          case ($urandom_range(9))
            0: ip = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            1: ip = (32'h1 << $urandom_range(31)) ^ ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
            default: ip = $urandom;
          endcase
          safe = walk_is_safe(ip);
          tries++;
        end while (!safe && tries < 8);
        if (safe) send_item(OP_LOOKUP, 20'($urandom), 8'($urandom), ip);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: one 24-bit node, v4 tree, empty data window
  task automatic test_reset_defaults();
    // node 0: left = 1 (the node count), right = 17 (separator end, window empty)
    send_item(OP_WRITE, 20'd0, 8'h00, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 20'd1, 8'h00, 32'h0);
    send_item(OP_WRITE, 20'd2, 8'h01, 32'h0);
    send_item(OP_WRITE, 20'd3, 8'h00, 32'h0);
    send_item(OP_WRITE, 20'd4, 8'h00, 32'h0);
    send_item(OP_WRITE, 20'd5, 8'h11, 32'h0);
    // top of the byte space
    send_item(OP_WRITE, 20'hF_FFFF, 8'hFF, 32'h0);
    send_item(OP_LOOKUP, 20'h0, 8'h0, 32'h0000_0000);
    send_item(OP_LOOKUP, 20'hF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    // right record back to node 0: all 32 steps stay in the tree
    send_item(OP_WRITE, 20'd5, 8'h00, 32'h0);
    send_item(OP_LOOKUP, 20'h0, 8'h0, 32'hFFFF_FFFF);
  endtask

  // node count zero: nothing to walk in either tree kind
  task automatic test_empty_tree();
    load_config(MODE_24, 1'b0, 0, 32'd0);
    send_item(OP_LOOKUP, 20'h0, 8'h0, $urandom);
    load_config(MODE_24, 1'b1, 0, 32'd0);
    send_item(OP_LOOKUP, 20'h0, 8'h0, $urandom);
  endtask

  // v6 tree whose prefix walk leaves the tree at once
  task automatic test_missing_v4_subtree();
    load_config(MODE_24, 1'b1, 4, 32'h10);
    send_item(OP_WRITE, 20'd2, 8'h04, 32'h0);
    send_item(OP_LOOKUP, 20'h0, 8'h0, 32'h1234_5678);
  endtask

  // v6 prefix looping on node 0, then an IPv4 walk into the data window
  task automatic test_v6_prefix_walk();
    load_config(MODE_24, 1'b1, 1, 32'h10);
    send_item(OP_WRITE, 20'd2, 8'h00, 32'h0);
    send_item(OP_WRITE, 20'd5, 8'h14, 32'h0);
    send_item(OP_LOOKUP, 20'h0, 8'h0, 32'h8000_0000);
    send_item(OP_LOOKUP, 20'h0, 8'h0, 32'h0000_0000);
  endtask

  // every record layout, both tree kinds, node count and window extremes
  task automatic test_layout_sweep();
    run_phase(MODE_24,     1'b0, 16,                 32'd100,      90, 0);
    run_phase(MODE_28,     1'b0, 349525,             32'hFFFF_FFFF, 90, 0);
    run_phase(MODE_32,     1'b1, 20,                 32'd1000,     45, 0);
    run_phase(MODE_32_ALT, 1'b0, (1 << NODE_W) - 1,  32'd0,        90, 0);
    run_phase(MODE_28,     1'b1, 12,                 $urandom,     45, 0);
    run_phase(MODE_24,     1'b1, 349525,             $urandom,     45, 0);
    run_phase(MODE_32,     1'b0, 1,                  32'd5,        45, 0);
  endtask

  // results held back for a long stretch while requests keep coming
  task automatic test_back_pressure();
    run_phase(MODE_28, 1'b0, 40, 32'd2000, 60, 400);
  endtask

  // no idling on either side for a whole phase
  task automatic test_steady_stream();
    no_idle = 1'b1;
    run_phase(MODE_24, 1'b0, 64, 32'd300, 80, 0);
    no_idle = 1'b0;
  endtask

  // random register settings until the request budget is used up
  task automatic test_random_configs();
    int nodes;
    logic [31:0] window;
    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(19))
        0:       nodes = 0;
        1, 2:    nodes = $urandom_range((1 << NODE_W) - 1, 1);
        default: nodes = $urandom_range(64, 1);
      endcase
      case ($urandom_range(4))
        0:       window = $urandom_range(100);
        1:       window = $urandom_range(5000);
        2:       window = 32'hFFFF_FFFF;
        default: window = $urandom;
      endcase
      run_phase(rec_mode_t'($urandom_range(3)), $urandom_range(9) < 3, nodes, window, 80, 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_NODE_COUNT;
    cfg_wdata          <= 32'd0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= OP_WRITE;
    in_ch.byte_address <= 20'd0;
    in_ch.byte_value   <= 8'd0;
    in_ch.ip_address   <= 32'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_empty_tree();
    test_missing_v4_subtree();
    test_v6_prefix_walk();
    test_layout_sweep();
    test_back_pressure();
    test_steady_stream();
    test_random_configs();

    // wait out the last answers, then give any stray beat time to show up
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d requests (%0d lookups, %0d tree writes) over %0d register settings",
             items_sent, lookups_sent, writes_sent, settings_loaded);
    $display("lookup outcomes: %0d not found, %0d found, %0d invalid, %0d without v4 subtree",
             outcome_tally[ST_NOT_FOUND], outcome_tally[ST_FOUND],
             outcome_tally[ST_INVALID], outcome_tally[ST_NO_V4]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
